[hdl/indexed_sequence_store_defines.svh]
// Assertion macros used by the top RTL file of the indexed sequence store.
// Each use stands on a line of its own and carries its own semicolon.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

`ifndef SYNTH
// Check a property at every rising edge outside reset.
`define ISQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("indexed_sequence_store: assertion failed");
// Check that a condition implies another in the next cycle.
`define ISQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_sequence_store: assertion failed");
`else
`define ISQ_ASSERT(lbl, clk, rst_n, prop)
`define ISQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/isq_pkg.sv]
package isq_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_OUT_W = 7;

  // Request codes
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Read value for a position past the end
  localparam logic signed [VAL_W-1:0] RD_INVALID = -32'sd1;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [CNT_OUT_W-1:0]    item_count;
  } out_word_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

[hdl/indexed_sequence_store.sv]
// Indexed sequence store: an ordered list of signed 32-bit values kept in a
// row of CAPACITY cells, position 0 in cell 0.
// Input channel in_valid / in_stall / in_word carries one request word:
// read at a position, insert before a position (position equal to the count
// appends) or delete at a position. Output channel out_valid / out_stall /
// out_word returns one result word per request: read value, status and the
// count after the request.
// The result is registered at the edge that accepts the request. Insert and
// delete finish in that same cycle, since every cell loads from its left or
// right neighbor at once, so one request is taken per cycle while in_stall
// is low. The read path is a CAPACITY-to-one select over the cells.
// in_stall is high while a result waits and out_stall is high; a stalled
// result holds and no new request is taken until it leaves.
// Reset clears the count and the output valid; cell contents are left as they
// are and are never read before they are written.
`include "indexed_sequence_store_defines.svh"

module indexed_sequence_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  isq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output isq_pkg::out_word_t out_word
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CIDX = $clog2(CAPACITY);
  localparam int unsigned PW   = (CW > isq_pkg::POS_W) ? CW : isq_pkg::POS_W;

  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              cnt_nxt;
  logic                       out_valid_r;
  isq_pkg::out_word_t         out_word_r;
  isq_pkg::out_word_t         out_word_nxt;
  logic                       in_acc;
  logic [PW-1:0]              pos_ext;
  logic [PW-1:0]              cnt_ext;
  logic [CIDX-1:0]            rd_idx;
  logic                       full;
  isq_pkg::cell_ctl_t         ctl;
  logic [isq_pkg::VAL_W-1:0]  cell_val [CAPACITY];
  logic [PW-1:0]              cnt_nxt_ext;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign pos_ext = PW'(in_word.position);
  assign cnt_ext = PW'(cnt_r);
  assign rd_idx  = pos_ext[CIDX-1:0];
  assign full    = (cnt_r == CW'(CAPACITY));

  // Decode the request into cell control, status and next count
  always_comb begin
    ctl          = '0;
    ctl.pos      = in_word.position;
    ctl.value    = in_word.value;
    cnt_nxt      = cnt_r;
    out_word_nxt = '0;
    unique case (in_word.req_type)
      isq_pkg::REQ_READ: begin
        if (pos_ext < cnt_ext) begin
          out_word_nxt.read_value = cell_val[rd_idx];
        end else begin
          out_word_nxt.read_value = isq_pkg::RD_INVALID;
          out_word_nxt.status     = isq_pkg::ST_RANGE;
        end
      end
      isq_pkg::REQ_INSERT: begin
        priority if (pos_ext > cnt_ext) begin
          out_word_nxt.status = isq_pkg::ST_RANGE;
        end else if (full) begin
          out_word_nxt.status = isq_pkg::ST_FULL;
        end else begin
          ctl.ins = in_acc;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      isq_pkg::REQ_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          out_word_nxt.status = isq_pkg::ST_RANGE;
        end else begin
          ctl.del = in_acc;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
        out_word_nxt.status = isq_pkg::ST_DONE;
      end
    endcase
    cnt_nxt_ext             = PW'(cnt_nxt);
    out_word_nxt.item_count = cnt_nxt_ext[isq_pkg::CNT_OUT_W-1:0];
  end

  // Build the cell chain, each cell wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [isq_pkg::VAL_W-1:0] left_v;
    logic [isq_pkg::VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    isq_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_val (left_v),
      .right_val(right_v),
      .val      (cell_val[i])
    );
  end

  // Advance count, hold the result while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ISQ_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(CAPACITY))
  `ISQ_ASSERT(a_stall_hold, clk, rst_n, (out_valid_r && out_stall) |-> in_stall)
  `ISQ_ASSERT_NEXT(a_acc_valid, clk, rst_n, in_acc, out_valid_r)
  `ISQ_ASSERT_NEXT(a_ins_count, clk, rst_n, ctl.ins, cnt_r == $past(cnt_r) + CW'(1))
  `ISQ_ASSERT_NEXT(a_del_count, clk, rst_n, ctl.del, cnt_r == $past(cnt_r) - CW'(1))

endmodule

[hdl/isq_cell.sv]
module isq_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  isq_pkg::cell_ctl_t       ctl,
  input  logic [isq_pkg::VAL_W-1:0] left_val,
  input  logic [isq_pkg::VAL_W-1:0] right_val,
  output logic [isq_pkg::VAL_W-1:0] val
);

  logic [isq_pkg::VAL_W-1:0] val_r;
  logic [isq_pkg::VAL_W-1:0] val_nxt;
  logic [31:0]               pos_w;

  assign pos_w = 32'(ctl.pos);

  // Load on insert at this slot, take left neighbor above an insert,
  // take right neighbor at or above a delete, else hold
  always_comb begin
    val_nxt = val_r;
    priority if (ctl.ins && pos_w == IDX) begin
      val_nxt = ctl.value;
    end else if (ctl.ins && pos_w < IDX) begin
      val_nxt = left_val;
    end else if (ctl.del && pos_w <= IDX) begin
      val_nxt = right_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import isq_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned RANDOM_WORDS = 750;
  localparam int unsigned PHASE_LEN = 125;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  typedef struct packed {
    in_word_t  w;
    logic      known;
    out_word_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Shadow list and the results still owed by the block
  logic signed [VAL_W-1:0] list_vals [DEPTH];
  int unsigned             list_len = 0;
  out_word_t               owed_results [$];
  logic                    failed = 1'b0;
  logic                    word_known = 1'b0;
  out_word_t               word_res = '0;

  indexed_sequence_store #(
    .CAPACITY(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #1 clk = ~clk;

  // Apply one request to the shadow list and return the result word it yields
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t   r;
    int unsigned p;
    r = '0;
    r.status = ST_DONE;
    p = w.position;
    case (w.req_type)
      REQ_READ: begin
        if (p < list_len) begin
          r.read_value = list_vals[p];
        end else begin
          r.read_value = RD_INVALID;
          r.status = ST_RANGE;
        end
      end
      REQ_INSERT: begin
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // shift the tail up by one, then drop the value in
          for (int unsigned i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = w.value;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.item_count = CNT_OUT_W'(list_len);
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] kind, int unsigned pos,
                                       logic [VAL_W-1:0] val, logic known,
                                       logic [VAL_W-1:0] rv, logic [1:0] st,
                                       int unsigned cnt);
    dir_row_t d;
    d.w.req_type = kind;
    d.w.position = POS_W'(pos);
    d.w.value = val;
    d.known = known;
    d.res.read_value = rv;
    d.res.status = st;
    d.res.item_count = CNT_OUT_W'(cnt);
    return d;
  endfunction

  // Pick a request word, mostly aimed at valid positions of the current list
  function automatic in_word_t next_request(phase_e ph);
    in_word_t    w;
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  w.req_type = (r < 80) ? REQ_INSERT : (r < 88) ? REQ_READ :
                             (r < 97) ? REQ_DELETE : REQ_UNUSED;
      PH_DRAIN: w.req_type = (r < 75) ? REQ_DELETE : (r < 85) ? REQ_INSERT :
                             (r < 97) ? REQ_READ : REQ_UNUSED;
      default:  w.req_type = (r < 35) ? REQ_INSERT : (r < 65) ? REQ_READ :
                             (r < 95) ? REQ_DELETE : REQ_UNUSED;
    endcase
    s = $urandom_range(0, 15);
    if (s == 0) begin
      w.position = POS_W'($urandom_range(0, 127));
    end else if (s == 1) begin
      w.position = '0;
    end else if (s == 2) begin
      w.position = POS_W'(list_len);
    end else if (w.req_type == REQ_INSERT) begin
      w.position = POS_W'($urandom_range(0, list_len));
    end else if (list_len > 0) begin
      w.position = POS_W'($urandom_range(0, list_len - 1));
    end else begin
      w.position = '0;
    end
    s = $urandom_range(0, 15);
    case (s)
      0:       w.value = 32'sh8000_0000;
      1:       w.value = 32'sh7fff_ffff;
      2:       w.value = -32'sd1;
      3:       w.value = '0;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  // Hold valid low for a random gap: often none, mostly short, a few long
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Present one word and hold it until the block takes it
  task automatic send_request(in_word_t w, logic known, out_word_t res);
    word_known = known;
    word_res = res;
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Check each result word against the oldest owed one, then log new requests
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_word);
          failed = 1'b1;
        end else begin
          want = owed_results.pop_front();
          if (out_word.read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d got %0d", $time,
                     want.read_value, out_word.read_value);
            failed = 1'b1;
          end
          if (out_word.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time,
                     want.status, out_word.status);
            failed = 1'b1;
          end
          if (out_word.item_count !== want.item_count) begin
            $display("%0t: item_count expected %0d got %0d", $time,
                     want.item_count, out_word.item_count);
            failed = 1'b1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_request(in_word);
        if (word_known) want = word_res;
        owed_results.push_back(want);
      end
    end
  end

  // Stall the result side in random bursts, with long free stretches now and then
  initial begin
    int unsigned run;
    forever begin
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 6);
      repeat (run) @(negedge clk);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(negedge clk);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [$];
    phase_e   ph;
    // empty list, range errors, extremes, head and tail inserts, unused code
    dir_rows.push_back(dir_row(REQ_READ, 0, 32'h0, 1'b1, RD_INVALID, ST_RANGE, 0));
    dir_rows.push_back(dir_row(REQ_DELETE, 0, 32'h0, 1'b1, 32'h0, ST_RANGE, 0));
    dir_rows.push_back(dir_row(REQ_INSERT, 1, 32'h5, 1'b1, 32'h0, ST_RANGE, 0));
    dir_rows.push_back(dir_row(REQ_INSERT, 0, 32'h8000_0000, 1'b1, 32'h0, ST_DONE, 1));
    dir_rows.push_back(dir_row(REQ_INSERT, 1, 32'h7fff_ffff, 1'b1, 32'h0, ST_DONE, 2));
    dir_rows.push_back(dir_row(REQ_INSERT, 0, 32'hffff_ffff, 1'b1, 32'h0, ST_DONE, 3));
    dir_rows.push_back(dir_row(REQ_INSERT, 1, 32'h0, 1'b1, 32'h0, ST_DONE, 4));
    dir_rows.push_back(dir_row(REQ_READ, 0, 32'h0, 1'b1, 32'hffff_ffff, ST_DONE, 4));
    dir_rows.push_back(dir_row(REQ_READ, 3, 32'h0, 1'b1, 32'h7fff_ffff, ST_DONE, 4));
    dir_rows.push_back(dir_row(REQ_READ, 4, 32'h0, 1'b1, RD_INVALID, ST_RANGE, 4));
    dir_rows.push_back(dir_row(REQ_READ, 127, 32'h0, 1'b1, RD_INVALID, ST_RANGE, 4));
    dir_rows.push_back(dir_row(REQ_INSERT, 127, 32'h1, 1'b1, 32'h0, ST_RANGE, 4));
    dir_rows.push_back(dir_row(REQ_INSERT, 5, 32'h1, 1'b1, 32'h0, ST_RANGE, 4));
    dir_rows.push_back(dir_row(REQ_DELETE, 4, 32'h0, 1'b1, 32'h0, ST_RANGE, 4));
    dir_rows.push_back(dir_row(REQ_DELETE, 127, 32'h0, 1'b1, 32'h0, ST_RANGE, 4));
    dir_rows.push_back(dir_row(REQ_UNUSED, 0, 32'hffff_ffff, 1'b1, 32'h0, ST_DONE, 4));
    dir_rows.push_back(dir_row(REQ_UNUSED, 127, 32'h0, 1'b1, 32'h0, ST_DONE, 4));
    dir_rows.push_back(dir_row(REQ_READ, 2, 32'h0, 1'b0, 32'h0, ST_DONE, 0));
    dir_rows.push_back(dir_row(REQ_DELETE, 3, 32'h0, 1'b0, 32'h0, ST_DONE, 0));
    dir_rows.push_back(dir_row(REQ_DELETE, 0, 32'h0, 1'b0, 32'h0, ST_DONE, 0));
    dir_rows.push_back(dir_row(REQ_READ, 0, 32'h0, 1'b0, 32'h0, ST_DONE, 0));
    dir_rows.push_back(dir_row(REQ_INSERT, 2, 32'h5555_5555, 1'b0, 32'h0, ST_DONE, 0));
    dir_rows.push_back(dir_row(REQ_INSERT, 1, 32'haaaa_aaaa, 1'b0, 32'h0, ST_DONE, 0));
    dir_rows.push_back(dir_row(REQ_READ, 1, 32'h0, 1'b0, 32'h0, ST_DONE, 0));

    // hold reset, then release at a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // walk the directed table
    foreach (dir_rows[i]) begin
      idle_gap();
      send_request(dir_rows[i].w, dir_rows[i].known, dir_rows[i].res);
    end

    // random words in fill, drain and mixed phases
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      ph = phase_e'((n / PHASE_LEN) % 3);
      idle_gap();
      send_request(next_request(ph), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain owed results, then give stray words time to show up
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/isq_pkg.sv
hdl/isq_cell.sv
hdl/indexed_sequence_store.sv
dv/tb.sv
